// ===== src/pcg32rg_pkg.sv =====
// ----------------------------------------------------------------------------
// PCG32 range generator package
// Constants, command codes and the XSH-RR output function of the generator.
// ----------------------------------------------------------------------------
package pcg32rg_pkg;

    localparam logic [63:0] PCG_MULT         = 64'd6364136223846793005;
    localparam logic [63:0] SEED_STATE_RESET = 64'h853c49e6748fea9b;
    localparam logic [63:0] SEED_SEQ_RESET   = 64'hda3e39cb94b95bdb;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_RAW      = 2'd0;
    localparam t_cmd CMD_UNBIASED = 2'd1;
    localparam t_cmd CMD_FAST     = 2'd2;
    localparam t_cmd CMD_RESEED   = 2'd3;

    localparam logic CFG_SEED_STATE    = 1'b0;
    localparam logic CFG_SEED_SEQUENCE = 1'b1;

    function automatic logic [31:0] xsh_rr(input logic [63:0] old);
        logic [63:0] mix;
        logic [31:0] xs;
        logic [4:0]  rot;
        logic [63:0] dbl;
        mix = ((old >> 18) ^ old) >> 27;
        xs  = mix[31:0];
        rot = old[63:59];
        dbl = {xs, xs} >> rot;
        return dbl[31:0];
    endfunction

endpackage

// ===== src/pcg32_range_generator_core.sv =====
// ----------------------------------------------------------------------------
// PCG32 range generator core
// PCG32 XSH-RR generator with raw, unbiased range, fast range and reseed
// requests, built around one shared 32x32 multiplier and a radix-2 divider.
// ----------------------------------------------------------------------------
// The block accepts no new request until the current one has its result
// registered. A draw latches the output word and then forms the 64-bit state
// update through the shared 32x32 multiplier. A fast range request then runs
// the bit-serial remainder. An unbiased range request first runs the remainder
// for the rejection threshold and repeats the draw for each rejected word.
// Raw and reseed requests need only the draw, and empty or inverted ranges
// skip it. After reset the block seeds itself before it takes its first request.
module pcg32_range_generator_core
    import pcg32rg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_min_value,
    input  logic [31:0] i_max_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_value,
    output logic        o_range_error
);

    localparam logic [2:0] S_BOOT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_PUSH = 3'd6;

    logic [2:0]  r_fsm;
    logic        r_silent;
    logic [63:0] r_seed_state;
    logic [63:0] r_seed_seq;
    logic [63:0] r_lcg;
    logic [63:0] r_inc;
    logic [63:0] r_acc;
    logic [63:0] r_prod;
    logic [1:0]  r_step;
    logic [31:0] r_draw;
    logic [31:0] r_thr;
    logic [31:0] r_min;
    logic [31:0] r_bound;
    logic [31:0] r_rem;
    logic [31:0] r_dvd;
    logic [4:0]  r_cnt;
    logic        r_div_thr;
    t_cmd        r_cmd;
    logic [31:0] r_res_value;
    logic        r_res_err;
    logic        r_out_valid;
    logic [31:0] r_out_value;
    logic        r_out_err;

    logic        in_accept;
    logic        out_take;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [32:0] div_t;
    logic [32:0] div_sub;
    logic [31:0] rem_n;
    logic [63:0] inc_n;
    logic [63:0] acc_hi;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_take  = r_out_valid && !i_out_stall;

    assign o_in_stall    = (r_fsm != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_value       = r_out_value;
    assign o_range_error = r_out_err;

    // Partial products of the low 64 bits of state * multiplier.
    assign mul_a = (r_step == 2'd2) ? r_lcg[63:32] : r_lcg[31:0];
    assign mul_b = (r_step == 2'd1) ? PCG_MULT[63:32] : PCG_MULT[31:0];
    assign mul_p = mul_a * mul_b;
    assign acc_hi = {r_prod[31:0], 32'b0};

    assign div_t   = {r_rem, r_dvd[31]};
    assign div_sub = div_t - {1'b0, r_bound};
    assign rem_n   = div_sub[32] ? div_t[31:0] : div_sub[31:0];

    assign inc_n = {r_seed_seq[62:0], 1'b1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_state <= SEED_STATE_RESET;
            r_seed_seq   <= SEED_SEQ_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEED_STATE:    r_seed_state <= i_cfg_data;
                CFG_SEED_SEQUENCE: r_seed_seq   <= i_cfg_data;
                default:           r_seed_state <= r_seed_state;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_BOOT;
            r_silent    <= 1'b1;
            r_out_valid <= 1'b0;
            r_step      <= 2'd0;
        end else begin
            if (out_take && r_fsm != S_PUSH) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_fsm)
                S_BOOT: begin
                    r_inc    <= {SEED_SEQ_RESET[62:0], 1'b1};
                    r_lcg    <= {SEED_SEQ_RESET[62:0], 1'b1} + SEED_STATE_RESET;
                    r_cmd    <= CMD_RESEED;
                    r_silent <= 1'b1;
                    r_fsm    <= S_LOAD;
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_cmd       <= i_cmd;
                        r_silent    <= 1'b0;
                        r_min       <= i_min_value;
                        r_bound     <= i_max_value - i_min_value;
                        r_res_value <= 32'd0;
                        r_res_err   <= 1'b0;
                        priority if (i_cmd == CMD_RAW) begin
                            r_fsm <= S_LOAD;
                        end else if (i_cmd == CMD_RESEED) begin
                            r_inc <= inc_n;
                            r_lcg <= inc_n + r_seed_state;
                            r_fsm <= S_LOAD;
                        end else if (i_min_value > i_max_value) begin
                            r_res_err <= 1'b1;
                            r_fsm     <= S_PUSH;
                        end else if (i_min_value == i_max_value) begin
                            r_res_value <= i_min_value;
                            r_fsm       <= S_PUSH;
                        end else if (i_cmd == CMD_UNBIASED) begin
                            r_rem     <= 32'd0;
                            r_dvd     <= i_min_value - i_max_value;
                            r_cnt     <= 5'd0;
                            r_div_thr <= 1'b1;
                            r_fsm     <= S_DIV;
                        end else begin
                            r_fsm <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    r_draw <= xsh_rr(r_lcg);
                    r_acc  <= r_inc;
                    r_step <= 2'd0;
                    r_fsm  <= S_MUL;
                end
                S_MUL: begin
                    r_step <= r_step + 2'd1;
                    r_prod <= mul_p;
                    unique case (r_step)
                        2'd0: r_acc <= r_acc;
                        2'd1: r_acc <= r_acc + r_prod;
                        2'd2: r_acc <= r_acc + acc_hi;
                        default: begin
                            r_lcg <= r_acc + acc_hi;
                            priority if (r_cmd == CMD_RESEED) begin
                                r_res_value <= 32'd0;
                                r_fsm       <= r_silent ? S_IDLE : S_PUSH;
                            end else if (r_cmd == CMD_RAW) begin
                                r_res_value <= r_draw;
                                r_fsm       <= S_PUSH;
                            end else if (r_cmd == CMD_UNBIASED && r_draw < r_thr) begin
                                r_fsm <= S_LOAD;
                            end else begin
                                r_rem     <= 32'd0;
                                r_dvd     <= r_draw;
                                r_cnt     <= 5'd0;
                                r_div_thr <= 1'b0;
                                r_fsm     <= S_DIV;
                            end
                        end
                    endcase
                end
                S_DIV: begin
                    r_rem <= rem_n;
                    r_dvd <= {r_dvd[30:0], 1'b0};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        if (r_div_thr) begin
                            r_thr <= rem_n;
                            r_fsm <= S_LOAD;
                        end else begin
                            r_fsm <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    r_res_value <= r_min + r_rem;
                    r_fsm       <= S_PUSH;
                end
                S_PUSH: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_res_value;
                        r_out_err   <= r_res_err;
                        r_fsm       <= S_IDLE;
                    end
                end
                default: begin
                    r_fsm <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_error |-> o_value == 32'd0)
        else $error("range error result carries a nonzero value");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("block ready right after taking a request");

    a_mul_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fsm == S_MUL && r_step == 2'd3 |=> r_fsm != S_MUL)
        else $error("multiply sequence overran its four steps");

    a_push_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fsm == S_PUSH && !(r_out_valid && i_out_stall) |=> o_out_valid)
        else $error("finished result not moved to the output register");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the PCG32 range generator core
// Drives raw, unbiased range, fast range and reseed requests through the
// valid/stall handshake and compares every result with an in-bench
// PCG32 XSH-RR predictor that tracks the generator state and seed registers.
// ----------------------------------------------------------------------------
module tb;
    import pcg32rg_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 250;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 160;

    typedef struct packed {
        logic [31:0] value;
        logic        range_error;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_SEED_STATE;
    logic [63:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_cmd = CMD_RAW;
    logic [31:0] i_min_value = '0;
    logic [31:0] i_max_value = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_value;
    logic        o_range_error;

    logic [63:0] gen_state;
    logic [63:0] gen_incr;
    logic [63:0] seed_st;
    logic [63:0] seed_seq;

    t_outcome    pending_q[$];
    int          send_idle_pct = 0;
    int          out_stall_pct = 0;
    int          hold_cycles = 0;
    int          quiet_cycles = 0;
    int          fail_count = 0;
    int          results_checked = 0;
    int          cmd_count[4] = '{0, 0, 0, 0};
    int          inverted_count = 0;
    int          empty_count = 0;
    int          cfg_writes = 0;

    pcg32_range_generator_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_min_value   (i_min_value),
        .i_max_value   (i_max_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_value       (o_value),
        .o_range_error (o_range_error)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [31:0] pcg_next_word();
        logic [63:0] prev;
        logic [31:0] xs;
        logic [4:0]  rot;
        logic [4:0]  lrot;
        prev      = gen_state;
        gen_state = prev * PCG_MULT + gen_incr;
        xs        = 32'(((prev >> 18) ^ prev) >> 27);
        rot       = prev[63:59];
        lrot      = 5'(5'd0 - rot);
        return (xs >> rot) | (xs << lrot);
    endfunction

    function automatic void pcg_reseed();
        gen_state = '0;
        gen_incr  = {seed_seq[62:0], 1'b1};
        void'(pcg_next_word());
        gen_state = gen_state + seed_st;
        void'(pcg_next_word());
    endfunction

    function automatic t_outcome predict_outcome(t_cmd c, logic [31:0] lo, logic [31:0] hi);
        t_outcome    o;
        logic [31:0] span;
        logic [31:0] floor_v;
        logic [31:0] w;
        o = '{value: 32'd0, range_error: 1'b0};
        if (c == CMD_RAW) begin
            o.value = pcg_next_word();
        end else if (c == CMD_RESEED) begin
            pcg_reseed();
        end else if (lo > hi) begin
            o.range_error = 1'b1;
        end else if (lo == hi) begin
            o.value = lo;
        end else begin
            span = hi - lo;
            if (c == CMD_UNBIASED) begin
                floor_v = (32'd0 - span) % span;
                do
                    w = pcg_next_word();
                while (w < floor_v);
            end else begin
                w = pcg_next_word();
            end
            o.value = lo + w % span;
        end
        return o;
    endfunction

    task automatic send_request(t_cmd c, logic [31:0] lo, logic [31:0] hi);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= c;
        i_min_value <= lo;
        i_max_value <= hi;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_q.push_back(predict_outcome(c, lo, hi));
        cmd_count[c]++;
        if (c == CMD_UNBIASED || c == CMD_FAST) begin
            if (lo > hi) inverted_count++;
            else if (lo == hi) empty_count++;
        end
    endtask

    task automatic send_random_request();
        t_cmd        c;
        logic [31:0] lo;
        logic [31:0] hi;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 25) c = CMD_RAW;
        else if (pick < 60) c = CMD_UNBIASED;
        else if (pick < 95) c = CMD_FAST;
        else c = CMD_RESEED;
        lo   = $urandom;
        pick = $urandom_range(99);
        if (pick < 55) begin
            hi = lo + ($urandom >> $urandom_range(31));
        end else if (pick < 65) begin
            hi = lo;
        end else if (pick < 75) begin
            hi = $urandom;
            lo = hi + 32'd1 + ($urandom >> $urandom_range(31));
        end else begin
            hi = $urandom;
        end
        send_request(c, lo, hi);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic quiesce();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx == CFG_SEED_STATE) seed_st = data;
        else seed_seq = data;
        cfg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_idle_pct = 20;
        out_stall_pct = 20;
        send_request(CMD_RAW, 32'd0, 32'd0);
        send_request(CMD_RAW, 32'hFFFF_FFFF, 32'd0);
        send_request(CMD_RESEED, 32'd5, 32'd2);
        send_request(CMD_RAW, 32'd0, 32'hFFFF_FFFF);
        drain_results();
    endtask

    task automatic test_range_cases();
        send_request(CMD_UNBIASED, 32'd0, 32'hFFFF_FFFF);
        send_request(CMD_FAST, 32'd0, 32'hFFFF_FFFF);
        send_request(CMD_UNBIASED, 32'd0, 32'h8000_0001);
        send_request(CMD_UNBIASED, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_request(CMD_FAST, 32'd7, 32'd7);
        send_request(CMD_UNBIASED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_UNBIASED, 32'd1, 32'd0);
        send_request(CMD_FAST, 32'hFFFF_FFFF, 32'd0);
        send_request(CMD_FAST, 32'd100, 32'd110);
        drain_results();
    endtask

    task automatic test_seed_extremes();
        logic [63:0] st_list[4];
        logic [63:0] seq_list[4];
        st_list  = '{64'd0, '1, 64'd0, '1};
        seq_list = '{64'd0, '1, '1, 64'd0};
        for (int k = 0; k < 4; k++) begin
            quiesce();
            write_register(CFG_SEED_STATE, st_list[k]);
            write_register(CFG_SEED_SEQUENCE, seq_list[k]);
            // The new seeds only take effect on the next reseed request.
            if (k == 0) send_request(CMD_RAW, 32'd0, 32'd0);
            send_request(CMD_RESEED, 32'd0, 32'd0);
            send_request(CMD_RAW, 32'd0, 32'd0);
        end
        drain_results();
    endtask

    task automatic test_random_phase(int items, int idle_pct, int stall_pct);
        quiesce();
        write_register(CFG_SEED_STATE, {$urandom, $urandom});
        write_register(CFG_SEED_SEQUENCE, {$urandom, $urandom});
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        send_request(CMD_RESEED, $urandom, $urandom);
        for (int k = 1; k < items; k++) send_random_request();
        drain_results();
    endtask

    task automatic test_output_hold();
        send_idle_pct = 0;
        out_stall_pct = 0;
        hold_cycles   = HOLD_CYCLES;
        for (int k = 0; k < 12; k++) send_random_request();
        drain_results();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles--;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                $error("result with no pending request: value %h range_error %b",
                       o_value, o_range_error);
                fail_count++;
            end else begin
                want = pending_q.pop_front();
                results_checked++;
                if (o_value !== want.value) begin
                    $error("value: expected %h, got %h", want.value, o_value);
                    fail_count++;
                end
                if (o_range_error !== want.range_error) begin
                    $error("range_error: expected %b, got %b",
                           want.range_error, o_range_error);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no request or result moved for %0d cycles.", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        seed_st  = SEED_STATE_RESET;
        seed_seq = SEED_SEQ_RESET;
        pcg_reseed();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_range_cases();
        test_seed_extremes();
        test_random_phase(PHASE_ITEMS, 32, 70);
        test_random_phase(PHASE_ITEMS, 70, 32);
        test_random_phase(PHASE_ITEMS, 0, 0);
        test_output_hold();

        drain_results();
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);
        if (pending_q.size() != 0) begin
            $error("%0d results never arrived", pending_q.size());
            fail_count++;
        end
        $display("Checked %0d results: %0d raw, %0d unbiased, %0d fast, %0d reseed requests.",
                 results_checked, cmd_count[CMD_RAW], cmd_count[CMD_UNBIASED],
                 cmd_count[CMD_FAST], cmd_count[CMD_RESEED]);
        $display("Ranges: %0d inverted, %0d empty; %0d seed writes; one %0d-cycle output hold.",
                 inverted_count, empty_count, cfg_writes, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
